### hw/rtl/hrd_pkg.sv
// hrd_pkg: types, codes, header strings and helper functions for the HTTP reply deframer.
// Depends on nothing; hrd_dp, hrd_ctrl, the top level and the testbench import it.
`default_nettype none
package hrd_pkg;

    localparam int HEAD_BYTES = 1024;
    localparam int BODY_BYTES = 4096;
    localparam int LINE_BYTES = 32;

    localparam int HC_W = $clog2(HEAD_BYTES);
    localparam int BC_W = $clog2(BODY_BYTES + 1);
    localparam int LC_W = $clog2(LINE_BYTES);

    localparam logic [2:0] FN_CONNECT = 3'd0;
    localparam logic [2:0] FN_START   = 3'd1;
    localparam logic [2:0] FN_BYTE    = 3'd2;
    localparam logic [2:0] FN_EOS     = 3'd3;
    localparam logic [2:0] FN_DISC    = 3'd4;

    typedef enum logic [1:0] {RS_IDLE, RS_BUSY, RS_DONE, RS_FAILED} t_rstate;
    typedef enum logic [1:0] {ER_NONE, ER_PROTO, ER_BIG, ER_CLOSED} t_err;
    typedef enum logic [2:0] {
        PH_HEAD, PH_BODY, PH_SIZE, PH_DATA, PH_CRLF, PH_TRAIL, PH_CLOSE, PH_DONE
    } t_phase;
    typedef enum logic [1:0] {CN_NONE, CN_CLOSE, CN_KEEP} t_conn;
    typedef enum logic [1:0] {HV_NONE, HV_CLEN, HV_TE, HV_CONN} t_hval;
    typedef enum logic [1:0] {LS_WS, LS_DIG, LS_END} t_lsub;

    localparam int STR_W = 136;
    localparam logic [STR_W-1:0] S_VER     = STR_W'("HTTP/1.");
    localparam logic [STR_W-1:0] S_CLEN    = STR_W'("content-length");
    localparam logic [STR_W-1:0] S_TE      = STR_W'("transfer-encoding");
    localparam logic [STR_W-1:0] S_CHUNKED = STR_W'("chunked");
    localparam logic [STR_W-1:0] S_CONN    = STR_W'("connection");
    localparam logic [STR_W-1:0] S_CLOSE   = STR_W'("close");
    localparam logic [STR_W-1:0] S_KEEP    = STR_W'("keep-alive");

    localparam int L_VER     = 7;
    localparam int L_CLEN    = 14;
    localparam int L_TE      = 17;
    localparam int L_CHUNKED = 7;
    localparam int L_CONN    = 10;
    localparam int L_CLOSE   = 5;
    localparam int L_KEEP    = 10;

    localparam int POS_W = $clog2(L_TE + 2);
    localparam int J_W   = 4;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF_HEX = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;

    localparam logic [15:0] STATUS_BIAS = 16'd5328;

    typedef struct packed {
        logic head_init;
        logic head_push;
        logic head_commit;
        logic load_len;
        logic load_size;
        logic dec_left;
        logic size_init;
        logic size_push;
        logic keep;
        logic body_init;
    } t_cmd;

    typedef struct packed {
        logic lf;
        logic head_full;
        logic head_end;
        logic head_ok;
        logic is_1xx;
        logic chunked;
        logic close_eff;
        logic have_len;
        logic len_zero;
        logic left_last;
        logic line_empty;
        logic size_zero;
    } t_stat;

    typedef struct packed {
        t_rstate state;
        t_err    err;
        logic    reuse;
        logic    open;
        logic    accepted;
    } t_view;

    function automatic logic [7:0] fn_char(input logic [STR_W-1:0] s, input int len,
                                           input int idx);
        int sh;
        sh = 8 * (len - 1 - idx);
        if (sh < 0 || sh > STR_W - 8) return 8'h00;
        return s[sh +: 8];
    endfunction

    function automatic logic [7:0] fn_lc(input logic [7:0] c);
        return (c >= CH_UA && c <= CH_UZ) ? c + 8'd32 : c;
    endfunction

    function automatic logic [J_W-1:0] fn_match(input logic [J_W-1:0] j, input logic [7:0] x,
                                                input logic [STR_W-1:0] s, input int len);
        if (x == fn_char(s, len, int'(j))) return j + 1'b1;
        if (x == fn_char(s, len, 0)) return J_W'(1);
        return '0;
    endfunction

    function automatic logic [31:0] fn_dec(input logic [31:0] v, input logic [3:0] d);
        logic [35:0] t;
        t = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {32'd0, d};
        return (|t[35:32]) ? '1 : t[31:0];
    endfunction

    function automatic logic [31:0] fn_hex(input logic [31:0] v, input logic [3:0] d);
        logic [35:0] t;
        t = {v, 4'b0000} + {32'd0, d};
        return (|t[35:32]) ? '1 : t[31:0];
    endfunction

endpackage
`default_nettype wire

### hw/rtl/hrd_if.sv
// hrd_req_if / hrd_rsp_if: valid-ready channels for requests in and results out.
// Stand-alone; used by the top level of the deframer.
`default_nettype none
interface hrd_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] func;
    logic [7:0] data_byte;
    modport source (output valid, func, data_byte, input ready);
    modport sink (input valid, func, data_byte, output ready);
endinterface

interface hrd_rsp_if;
    logic               valid;
    logic               ready;
    logic               body_valid;
    logic [7:0]         body_byte;
    logic [1:0]         request_state;
    logic [1:0]         error_code;
    logic signed [15:0] http_status;
    logic               reusable;
    logic               truncated;
    logic               start_accepted;
    logic               needs_reconnect;
    modport source (output valid, body_valid, body_byte, request_state, error_code,
                    http_status, reusable, truncated, start_accepted, needs_reconnect,
                    input ready);
    modport sink (input valid, body_valid, body_byte, request_state, error_code,
                  http_status, reusable, truncated, start_accepted, needs_reconnect,
                  output ready);
endinterface
`default_nettype wire

### hw/rtl/http_reply_deframer.sv
// HTTP/1.x reply deframer. Every request (connect, start, reply byte, end of stream,
// disconnect) gives exactly one result showing the state after it. Head bytes are
// parsed as they stream in, so nothing is buffered and no walk is needed at the blank
// line: one request per cycle, sustained while results are read. A single result
// register sits between the sides; a request is taken whenever that register is
// empty or being read out. Depends on hrd_pkg, hrd_if, hrd_ctrl and hrd_dp.
`default_nettype none
module http_reply_deframer import hrd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hrd_req_if.sink   i_req,
    hrd_rsp_if.source o_rsp
);

    logic               go;
    logic               r_ov;
    t_cmd               cmd;
    t_stat              stat;
    t_view              view;
    logic               body_valid;
    logic [7:0]         body_byte;
    logic signed [15:0] status;
    logic               trunc;

    assign i_req.ready = !r_ov || o_rsp.ready;
    assign go          = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (go) begin
            r_ov <= 1'b1;
        end else if (o_rsp.ready) begin
            r_ov <= 1'b0;
        end
    end

    hrd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (go),
        .i_func  (i_req.func),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_view  (view)
    );

    hrd_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_go         (go),
        .i_byte       (i_req.data_byte),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_body_valid (body_valid),
        .o_body_byte  (body_byte),
        .o_status     (status),
        .o_trunc      (trunc)
    );

    assign o_rsp.valid           = r_ov;
    assign o_rsp.body_valid      = body_valid;
    assign o_rsp.body_byte       = body_byte;
    assign o_rsp.request_state   = view.state;
    assign o_rsp.error_code      = view.err;
    assign o_rsp.http_status     = status;
    assign o_rsp.reusable        = view.reuse;
    assign o_rsp.truncated       = trunc;
    assign o_rsp.start_accepted  = view.accepted;
    assign o_rsp.needs_reconnect = !view.open || !view.reuse || view.state == RS_FAILED;

`ifndef NO_ASSERTIONS
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && view.accepted |-> view.state == RS_BUSY)
        else $error("start accepted but request not busy");

    a_busy_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        view.state == RS_BUSY |-> view.err == ER_NONE)
        else $error("error code set while busy");

    a_fail_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        view.state == RS_FAILED && view.open |-> view.err != ER_NONE)
        else $error("failed request without error code");
`endif

endmodule
`default_nettype wire

### hw/rtl/hrd_dp.sv
// hrd_dp: datapath of the deframer: streaming head parser, chunk-size parser,
// length and body counters. Depends on hrd_pkg; driven by hrd_ctrl commands.
`default_nettype none
module hrd_dp import hrd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_go,
    input  logic [7:0]         i_byte,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    output logic               o_body_valid,
    output logic [7:0]         o_body_byte,
    output logic signed [15:0] o_status,
    output logic               o_trunc
);

    logic [HC_W-1:0]  r_hc, n_hc;
    logic [7:0]       r_b1, n_b1, r_b2, n_b2, r_b3, n_b3;
    logic             r_ver_ok, n_ver_ok, r_c7z, n_c7z;
    logic [7:0]       r_c9, n_c9, r_c10, n_c10, r_c11, n_c11;
    logic             r_line0, n_line0, r_stop, n_stop;
    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_m_clen, n_m_clen, r_m_te, n_m_te, r_m_conn, n_m_conn;
    t_hval            r_hv, n_hv;
    t_lsub            r_lsub, n_lsub;
    logic [31:0]      r_plen, n_plen;
    logic             r_have, n_have, r_pchunk, n_pchunk;
    t_conn            r_conn, n_conn;
    logic [J_W-1:0]   r_j_ch, n_j_ch, r_j_cl, n_j_cl, r_j_kp, n_j_kp;
    logic             r_f_ch, n_f_ch, r_f_cl, n_f_cl, r_f_kp, n_f_kp;
    logic [15:0]      r_status, n_status;
    logic [31:0]      r_left, n_left;
    logic [LC_W-1:0]  r_sc, n_sc;
    logic [31:0]      r_hex, n_hex;
    logic             r_hstop, n_hstop, r_cr0, n_cr0;
    logic [BC_W-1:0]  r_bc, n_bc;
    logic             r_trunc, n_trunc;
    logic             r_bv, n_bv;
    logic [7:0]       r_bbyte, n_bbyte;

    logic [7:0]         lc;
    logic               is_dig, is_hex;
    logic [3:0]         dig_val, hex_val;
    logic [7:0]         e11;
    logic [15:0]        st_sum;
    logic signed [15:0] st;
    logic [J_W-1:0]     j_ch, j_cl, j_kp;

    always_comb begin
        lc      = fn_lc(i_byte);
        is_dig  = i_byte >= CH_0 && i_byte <= CH_9;
        dig_val = 4'(i_byte - CH_0);
        is_hex  = (lc >= CH_0 && lc <= CH_9) || (lc >= CH_LA && lc <= CH_LF_HEX);
        hex_val = (lc >= CH_LA) ? 4'(lc - CH_LA + 8'd10) : 4'(lc - CH_0);
        e11     = (r_hc == HC_W'(11)) ? i_byte : r_c11;
        st_sum  = 16'(r_c9) * 16'd100 + 16'(r_c10) * 16'd10 + 16'(e11);
        st      = signed'(st_sum - STATUS_BIAS);
        j_ch    = fn_match(r_j_ch, lc, S_CHUNKED, L_CHUNKED);
        j_cl    = fn_match(r_j_cl, lc, S_CLOSE, L_CLOSE);
        j_kp    = fn_match(r_j_kp, lc, S_KEEP, L_KEEP);

        o_stat.lf         = i_byte == CH_LF;
        o_stat.head_full  = r_hc >= HC_W'(HEAD_BYTES - 1);
        o_stat.head_end   = i_byte == CH_LF && r_hc >= HC_W'(1) &&
                            (r_b1 == CH_LF || (r_hc >= HC_W'(3) && r_b3 == CH_CR &&
                             r_b2 == CH_LF && r_b1 == CH_CR));
        o_stat.head_ok    = r_hc >= HC_W'(11) && r_ver_ok;
        o_stat.is_1xx     = st >= 16'sd100 && st < 16'sd200;
        o_stat.chunked    = r_pchunk;
        o_stat.close_eff  = (r_conn == CN_CLOSE) ? 1'b1 : (r_conn == CN_KEEP) ? 1'b0 : r_c7z;
        o_stat.have_len   = r_have;
        o_stat.len_zero   = r_plen == 32'd0;
        o_stat.left_last  = r_left <= 32'd1;
        o_stat.line_empty = r_sc == '0 || (r_sc == LC_W'(1) && r_cr0);
        o_stat.size_zero  = r_hex == 32'd0;
    end

    always_comb begin
        n_hc = r_hc; n_b1 = r_b1; n_b2 = r_b2; n_b3 = r_b3;
        n_ver_ok = r_ver_ok; n_c7z = r_c7z; n_c9 = r_c9; n_c10 = r_c10; n_c11 = r_c11;
        n_line0 = r_line0; n_stop = r_stop; n_pos = r_pos;
        n_m_clen = r_m_clen; n_m_te = r_m_te; n_m_conn = r_m_conn;
        n_hv = r_hv; n_lsub = r_lsub; n_plen = r_plen; n_have = r_have;
        n_pchunk = r_pchunk; n_conn = r_conn;
        n_j_ch = r_j_ch; n_j_cl = r_j_cl; n_j_kp = r_j_kp;
        n_f_ch = r_f_ch; n_f_cl = r_f_cl; n_f_kp = r_f_kp;
        n_status = r_status; n_left = r_left;
        n_sc = r_sc; n_hex = r_hex; n_hstop = r_hstop; n_cr0 = r_cr0;
        n_bc = r_bc; n_trunc = r_trunc; n_bv = r_bv; n_bbyte = r_bbyte;

        if (i_go) begin
            n_bv    = 1'b0;
            n_bbyte = 8'h00;
        end

        if (i_cmd.head_push) begin
            n_hc = r_hc + 1'b1;
            n_b3 = r_b2; n_b2 = r_b1; n_b1 = i_byte;
            if (r_hc < HC_W'(L_VER))
                n_ver_ok = r_ver_ok && (i_byte == fn_char(S_VER, L_VER, int'(r_hc)));
            if (r_hc == HC_W'(7))  n_c7z = i_byte == CH_0;
            if (r_hc == HC_W'(9))  n_c9 = i_byte;
            if (r_hc == HC_W'(10)) n_c10 = i_byte;
            if (r_hc == HC_W'(11)) n_c11 = i_byte;
            if (i_byte == CH_LF) begin
                if (!r_line0 && !r_stop) begin
                    if (r_hv == HV_TE) n_pchunk = r_f_ch;
                    if (r_hv == HV_CONN) begin
                        if (r_f_cl) n_conn = CN_CLOSE;
                        else if (r_f_kp) n_conn = CN_KEEP;
                    end
                    if (r_pos == '0 || (r_pos == POS_W'(1) && r_b1 == CH_CR)) n_stop = 1'b1;
                end
                n_line0 = 1'b0;
                n_pos = '0;
                n_m_clen = 1'b1; n_m_te = 1'b1; n_m_conn = 1'b1;
                n_hv = HV_NONE;
                n_j_ch = '0; n_j_cl = '0; n_j_kp = '0;
                n_f_ch = 1'b0; n_f_cl = 1'b0; n_f_kp = 1'b0;
            end else if (!r_line0 && !r_stop) begin
                if (r_pos != '1) n_pos = r_pos + 1'b1;
                case (r_hv)
                    HV_NONE: begin
                        if (r_pos < POS_W'(L_CLEN))
                            n_m_clen = r_m_clen && lc == fn_char(S_CLEN, L_CLEN, int'(r_pos));
                        else if (r_pos == POS_W'(L_CLEN) && r_m_clen && i_byte == CH_COLON) begin
                            n_hv = HV_CLEN;
                            n_plen = '0;
                            n_have = 1'b1;
                            n_lsub = LS_WS;
                        end
                        if (r_pos < POS_W'(L_TE))
                            n_m_te = r_m_te && lc == fn_char(S_TE, L_TE, int'(r_pos));
                        else if (r_pos == POS_W'(L_TE) && r_m_te && i_byte == CH_COLON)
                            n_hv = HV_TE;
                        if (r_pos < POS_W'(L_CONN))
                            n_m_conn = r_m_conn && lc == fn_char(S_CONN, L_CONN, int'(r_pos));
                        else if (r_pos == POS_W'(L_CONN) && r_m_conn && i_byte == CH_COLON)
                            n_hv = HV_CONN;
                    end
                    HV_CLEN: begin
                        case (r_lsub)
                            LS_WS: begin
                                if (is_dig) begin
                                    n_plen = fn_dec(r_plen, dig_val);
                                    n_lsub = LS_DIG;
                                end else if (i_byte != CH_SP && i_byte != CH_TAB) begin
                                    n_lsub = LS_END;
                                end
                            end
                            LS_DIG: begin
                                if (is_dig) n_plen = fn_dec(r_plen, dig_val);
                                else n_lsub = LS_END;
                            end
                            default: ;
                        endcase
                    end
                    HV_TE: begin
                        n_f_ch = r_f_ch || j_ch == J_W'(L_CHUNKED);
                        n_j_ch = (j_ch == J_W'(L_CHUNKED)) ? '0 : j_ch;
                    end
                    HV_CONN: begin
                        n_f_cl = r_f_cl || j_cl == J_W'(L_CLOSE);
                        n_j_cl = (j_cl == J_W'(L_CLOSE)) ? '0 : j_cl;
                        n_f_kp = r_f_kp || j_kp == J_W'(L_KEEP);
                        n_j_kp = (j_kp == J_W'(L_KEEP)) ? '0 : j_kp;
                    end
                    default: ;
                endcase
            end
        end

        if (i_cmd.head_commit) n_status = st;

        if (i_cmd.head_init) begin
            n_hc = '0; n_ver_ok = 1'b1; n_line0 = 1'b1; n_stop = 1'b0; n_pos = '0;
            n_m_clen = 1'b1; n_m_te = 1'b1; n_m_conn = 1'b1;
            n_hv = HV_NONE; n_have = 1'b0; n_pchunk = 1'b0; n_conn = CN_NONE;
            n_j_ch = '0; n_j_cl = '0; n_j_kp = '0;
            n_f_ch = 1'b0; n_f_cl = 1'b0; n_f_kp = 1'b0;
        end

        if (i_cmd.load_len) n_left = r_plen;
        if (i_cmd.load_size) n_left = r_hex;
        if (i_cmd.dec_left && r_left != 32'd0) n_left = r_left - 32'd1;

        if (i_cmd.size_push && r_sc < LC_W'(LINE_BYTES - 1)) begin
            if (r_sc == '0) n_cr0 = i_byte == CH_CR;
            if (!r_hstop) begin
                if (is_hex) n_hex = fn_hex(r_hex, hex_val);
                else n_hstop = 1'b1;
            end
            n_sc = r_sc + 1'b1;
        end
        if (i_cmd.size_init) begin
            n_sc = '0; n_hex = '0; n_hstop = 1'b0;
        end

        if (i_cmd.keep) begin
            if (r_bc < BC_W'(BODY_BYTES)) begin
                n_bv = 1'b1;
                n_bbyte = i_byte;
                n_bc = r_bc + 1'b1;
            end else begin
                n_trunc = 1'b1;
            end
        end
        if (i_cmd.body_init) begin
            n_bc = '0; n_trunc = 1'b0; n_status = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hc <= '0; r_b1 <= '0; r_b2 <= '0; r_b3 <= '0;
            r_ver_ok <= 1'b1; r_c7z <= 1'b0; r_c9 <= '0; r_c10 <= '0; r_c11 <= '0;
            r_line0 <= 1'b1; r_stop <= 1'b0; r_pos <= '0;
            r_m_clen <= 1'b1; r_m_te <= 1'b1; r_m_conn <= 1'b1;
            r_hv <= HV_NONE; r_lsub <= LS_WS; r_plen <= '0; r_have <= 1'b0;
            r_pchunk <= 1'b0; r_conn <= CN_NONE;
            r_j_ch <= '0; r_j_cl <= '0; r_j_kp <= '0;
            r_f_ch <= 1'b0; r_f_cl <= 1'b0; r_f_kp <= 1'b0;
            r_status <= '0; r_left <= '0;
            r_sc <= '0; r_hex <= '0; r_hstop <= 1'b0; r_cr0 <= 1'b0;
            r_bc <= '0; r_trunc <= 1'b0; r_bv <= 1'b0; r_bbyte <= '0;
        end else begin
            r_hc <= n_hc; r_b1 <= n_b1; r_b2 <= n_b2; r_b3 <= n_b3;
            r_ver_ok <= n_ver_ok; r_c7z <= n_c7z; r_c9 <= n_c9; r_c10 <= n_c10;
            r_c11 <= n_c11;
            r_line0 <= n_line0; r_stop <= n_stop; r_pos <= n_pos;
            r_m_clen <= n_m_clen; r_m_te <= n_m_te; r_m_conn <= n_m_conn;
            r_hv <= n_hv; r_lsub <= n_lsub; r_plen <= n_plen; r_have <= n_have;
            r_pchunk <= n_pchunk; r_conn <= n_conn;
            r_j_ch <= n_j_ch; r_j_cl <= n_j_cl; r_j_kp <= n_j_kp;
            r_f_ch <= n_f_ch; r_f_cl <= n_f_cl; r_f_kp <= n_f_kp;
            r_status <= n_status; r_left <= n_left;
            r_sc <= n_sc; r_hex <= n_hex; r_hstop <= n_hstop; r_cr0 <= n_cr0;
            r_bc <= n_bc; r_trunc <= n_trunc; r_bv <= n_bv; r_bbyte <= n_bbyte;
        end
    end

    assign o_body_valid = r_bv;
    assign o_body_byte  = r_bbyte;
    assign o_status     = signed'(r_status);
    assign o_trunc      = r_trunc;

endmodule
`default_nettype wire

### hw/rtl/hrd_ctrl.sv
// hrd_ctrl: request state, error, connection flags and framing phase state machine.
// Depends on hrd_pkg; issues commands to hrd_dp and reads its status.
`default_nettype none
module hrd_ctrl import hrd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_go,
    input  logic [2:0] i_func,
    input  t_stat      i_stat,
    output t_cmd       o_cmd,
    output t_view      o_view
);

    t_rstate r_state, n_state;
    t_err    r_err, n_err;
    t_phase  r_phase, n_phase;
    logic    r_open, n_open, r_reuse, n_reuse, r_close, n_close, r_acc, n_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= RS_IDLE;
            r_err   <= ER_NONE;
            r_phase <= PH_HEAD;
            r_open  <= 1'b0;
            r_reuse <= 1'b0;
            r_close <= 1'b0;
            r_acc   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_err   <= n_err;
            r_phase <= n_phase;
            r_open  <= n_open;
            r_reuse <= n_reuse;
            r_close <= n_close;
            r_acc   <= n_acc;
        end
    end

    always_comb begin
        n_state = r_state;
        n_err   = r_err;
        n_phase = r_phase;
        n_open  = r_open;
        n_reuse = r_reuse;
        n_close = r_close;
        n_acc   = r_acc;
        o_cmd   = '0;
        if (i_go) begin
            n_acc = 1'b0;
            case (i_func)
                FN_CONNECT: begin
                    n_open  = 1'b1;
                    n_reuse = 1'b1;
                    n_state = RS_IDLE;
                    n_err   = ER_NONE;
                end
                FN_START: begin
                    if (r_state != RS_BUSY && r_open) begin
                        n_acc   = 1'b1;
                        n_state = RS_BUSY;
                        n_err   = ER_NONE;
                        n_phase = PH_HEAD;
                        n_close = 1'b0;
                        o_cmd.head_init = 1'b1;
                        o_cmd.body_init = 1'b1;
                    end
                end
                FN_BYTE: begin
                    if (r_state == RS_BUSY) begin
                        case (r_phase)
                            PH_HEAD: begin
                                if (i_stat.head_full) begin
                                    n_state = RS_FAILED;
                                    n_err   = ER_BIG;
                                    n_reuse = 1'b0;
                                end else begin
                                    o_cmd.head_push = 1'b1;
                                    if (i_stat.head_end) begin
                                        if (!i_stat.head_ok) begin
                                            n_state = RS_FAILED;
                                            n_err   = ER_PROTO;
                                            n_reuse = 1'b0;
                                        end else begin
                                            o_cmd.head_commit = 1'b1;
                                            n_close = i_stat.close_eff;
                                            if (i_stat.is_1xx) begin
                                                o_cmd.head_init = 1'b1;
                                            end else if (i_stat.chunked) begin
                                                n_phase = PH_SIZE;
                                                o_cmd.size_init = 1'b1;
                                            end else if (i_stat.have_len) begin
                                                n_phase = PH_BODY;
                                                o_cmd.load_len = 1'b1;
                                                if (i_stat.len_zero) begin
                                                    n_phase = PH_DONE;
                                                    n_reuse = !i_stat.close_eff;
                                                    n_state = RS_DONE;
                                                end
                                            end else begin
                                                n_phase = PH_CLOSE;
                                                n_close = 1'b1;
                                            end
                                        end
                                    end
                                end
                            end
                            PH_BODY: begin
                                o_cmd.keep     = 1'b1;
                                o_cmd.dec_left = 1'b1;
                                if (i_stat.left_last) begin
                                    n_phase = PH_DONE;
                                    n_reuse = !r_close;
                                    n_state = RS_DONE;
                                end
                            end
                            PH_SIZE, PH_TRAIL: begin
                                if (!i_stat.lf) begin
                                    o_cmd.size_push = 1'b1;
                                end else begin
                                    o_cmd.size_init = 1'b1;
                                    if (r_phase == PH_TRAIL) begin
                                        if (i_stat.line_empty) begin
                                            n_phase = PH_DONE;
                                            n_reuse = !r_close;
                                            n_state = RS_DONE;
                                        end
                                    end else begin
                                        o_cmd.load_size = 1'b1;
                                        n_phase = i_stat.size_zero ? PH_TRAIL : PH_DATA;
                                    end
                                end
                            end
                            PH_DATA: begin
                                o_cmd.keep     = 1'b1;
                                o_cmd.dec_left = 1'b1;
                                if (i_stat.left_last) begin
                                    n_phase = PH_CRLF;
                                    o_cmd.size_init = 1'b1;
                                end
                            end
                            PH_CRLF: begin
                                if (i_stat.lf) n_phase = PH_SIZE;
                            end
                            PH_CLOSE: begin
                                o_cmd.keep = 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
                FN_EOS: begin
                    if (r_state == RS_BUSY && r_phase == PH_CLOSE) begin
                        n_phase = PH_DONE;
                        n_state = RS_DONE;
                    end
                    n_open  = 1'b0;
                    n_reuse = 1'b0;
                    if (n_state == RS_BUSY) begin
                        n_state = RS_FAILED;
                        n_err   = ER_CLOSED;
                    end
                end
                FN_DISC: begin
                    n_open = 1'b0;
                    if (r_state == RS_BUSY) begin
                        n_state = RS_FAILED;
                        n_err   = ER_CLOSED;
                        n_reuse = 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_view.state    = r_state;
    assign o_view.err      = r_err;
    assign o_view.reuse    = r_reuse;
    assign o_view.open     = r_open;
    assign o_view.accepted = r_acc;

endmodule
`default_nettype wire

### bench/tb_http_reply_deframer.sv
// Self-checking testbench for http_reply_deframer: drives connection events and reply
// bytes, predicts every result with its own deframer model and checks them in order.
// Depends on hrd_pkg, hrd_if (hrd_req_if, hrd_rsp_if) and the deframer RTL.
`timescale 1ns / 100ps
module tb_http_reply_deframer;
    import hrd_pkg::*;

    localparam int IDLE_LIMIT   = 3000;
    localparam int RANDOM_ITEMS = 2000;
    localparam longint SAT32    = 64'hFFFF_FFFF;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] data_byte;
    } t_request;

    typedef struct packed {
        logic        body_valid;
        logic [7:0]  body_byte;
        t_rstate     request_state;
        t_err        error_code;
        logic [15:0] http_status;
        logic        reusable;
        logic        truncated;
        logic        start_accepted;
        logic        needs_reconnect;
    } t_reply_view;

    logic i_clk;
    logic i_rst_n;

    hrd_req_if req_ch ();
    hrd_rsp_if rsp_ch ();

    http_reply_deframer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    // deframer model state
    t_rstate     m_state;
    t_err        m_err;
    t_phase      m_phase;
    logic [7:0]  m_head [HEAD_BYTES];
    int          m_head_cnt;
    logic [15:0] m_status;
    logic [31:0] m_left;
    logic        m_chunked, m_close, m_reuse, m_open, m_trunc;
    logic [7:0]  m_line [LINE_BYTES];
    int          m_line_cnt;
    int          m_body_cnt;
    logic        m_out_v;
    logic [7:0]  m_out_b;

    t_request    pending_q[$];
    t_reply_view view_q[$];

    int  n_req, n_rsp, n_body, n_done, n_failed, n_errors, idle_cycles;
    logic req_taken;
    logic gen_link_up;
    int  burst_left, gap_left;
    bit  pause_done;
    int  long_stall_cnt;
    bit  long_stall_done;
    int  pattern_cnt, pattern_mode;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function void fail_reply(input t_err e);
        if (m_state == RS_BUSY) begin
            m_state = RS_FAILED;
            m_err   = e;
        end
        m_reuse = 1'b0;
    endfunction

    function void finish_reply();
        m_phase = PH_DONE;
        m_reuse = !m_close;
        if (m_state == RS_BUSY) m_state = RS_DONE;
    endfunction

    function void keep_body(input logic [7:0] c);
        if (m_body_cnt < BODY_BYTES) begin
            m_out_v = 1'b1;
            m_out_b = c;
            m_body_cnt++;
        end else begin
            m_trunc = 1'b1;
        end
    endfunction

    function int find_lf(input int p);
        while (p < m_head_cnt && m_head[p] != CH_LF) p++;
        return p;
    endfunction

    function bit header_is(input int s, input int n, input string nm, output int v);
        int k;
        k = nm.len();
        v = 0;
        if (n <= k || m_head[s+k] != CH_COLON) return 1'b0;
        for (int i = 0; i < k; i++)
            if (to_lower(m_head[s+i]) != nm[i]) return 1'b0;
        v = s + k + 1;
        while (v < s + n && (m_head[v] == CH_SP || m_head[v] == CH_TAB)) v++;
        return 1'b1;
    endfunction

    function bit token_found(input int v, input int e, input string t);
        int k, i;
        k = t.len();
        for (; v + k <= e; v++) begin
            i = 0;
            while (i < k && to_lower(m_head[v+i]) == t[i]) i++;
            if (i == k) return 1'b1;
        end
        return 1'b0;
    endfunction

    function void scan_head();
        string  ver;
        int     p, eol, n, v, st;
        bit     have_len, ver_ok;
        longint len;
        ver = "HTTP/1.";
        have_len = 1'b0;
        len = 0;
        ver_ok = (m_head_cnt >= 12);
        for (int i = 0; i < 7; i++)
            if (m_head[i] != ver[i]) ver_ok = 1'b0;
        if (!ver_ok) begin
            fail_reply(ER_PROTO);
            return;
        end
        st = (int'(m_head[9]) - 48) * 100 + (int'(m_head[10]) - 48) * 10 +
             (int'(m_head[11]) - 48);
        m_status  = st[15:0];
        m_close   = (m_head[7] == "0");
        m_chunked = 1'b0;
        eol = find_lf(0);
        p = eol + 1;
        while (p < m_head_cnt) begin
            eol = find_lf(p);
            if (eol >= m_head_cnt) break;
            n = eol - p;
            if (n > 0 && m_head[p+n-1] == CH_CR) n--;
            if (n == 0) break;
            if (header_is(p, n, "content-length", v)) begin
                len = 0;
                while (v < p + n && m_head[v] >= CH_0 && m_head[v] <= CH_9) begin
                    len = len * 10 + longint'(m_head[v] - CH_0);
                    if (len > SAT32) len = SAT32;
                    v++;
                end
                have_len = 1'b1;
            end else if (header_is(p, n, "transfer-encoding", v)) begin
                m_chunked = token_found(v, p + n, "chunked");
            end else if (header_is(p, n, "connection", v)) begin
                if (token_found(v, p + n, "close")) m_close = 1'b1;
                else if (token_found(v, p + n, "keep-alive")) m_close = 1'b0;
            end
            p = eol + 1;
        end
        if (st >= 100 && st < 200) begin
            m_head_cnt = 0;
            return;
        end
        if (m_chunked) begin
            m_phase = PH_SIZE;
            m_line_cnt = 0;
        end else if (have_len) begin
            m_phase = PH_BODY;
            m_left  = len[31:0];
            if (len == 0) finish_reply();
        end else begin
            m_phase = PH_CLOSE;
            m_close = 1'b1;
        end
    endfunction

    function void size_line_done();
        int         n, d;
        longint     v;
        logic [7:0] x;
        n = m_line_cnt;
        if (n > 0 && m_line[n-1] == CH_CR) n--;
        if (m_phase == PH_TRAIL) begin
            if (n == 0) finish_reply();
        end else begin
            v = 0;
            for (int i = 0; i < n; i++) begin
                x = to_lower(m_line[i]);
                if (x >= "0" && x <= "9") d = x - "0";
                else if (x >= "a" && x <= "f") d = x - "a" + 10;
                else break;
                v = v * 16 + d;
                if (v > SAT32) v = SAT32;
            end
            m_left  = v[31:0];
            m_phase = (v != 0) ? PH_DATA : PH_TRAIL;
        end
        m_line_cnt = 0;
    endfunction

    function void feed_byte(input logic [7:0] c);
        if (m_state != RS_BUSY) return;
        case (m_phase)
            PH_HEAD: begin
                if (m_head_cnt >= HEAD_BYTES - 1) begin
                    fail_reply(ER_BIG);
                    return;
                end
                m_head[m_head_cnt++] = c;
                if (c == CH_LF && m_head_cnt >= 2 &&
                    (m_head[m_head_cnt-2] == CH_LF ||
                     (m_head_cnt >= 4 && m_head[m_head_cnt-4] == CH_CR &&
                      m_head[m_head_cnt-3] == CH_LF && m_head[m_head_cnt-2] == CH_CR)))
                    scan_head();
            end
            PH_BODY: begin
                keep_body(c);
                if (m_left != 0) m_left--;
                if (m_left == 0) finish_reply();
            end
            PH_SIZE, PH_TRAIL: begin
                if (c != CH_LF) begin
                    if (m_line_cnt < LINE_BYTES - 1) m_line[m_line_cnt++] = c;
                end else begin
                    size_line_done();
                end
            end
            PH_DATA: begin
                keep_body(c);
                if (m_left != 0) m_left--;
                if (m_left == 0) begin
                    m_phase = PH_CRLF;
                    m_line_cnt = 0;
                end
            end
            PH_CRLF: if (c == CH_LF) m_phase = PH_SIZE;
            PH_CLOSE: keep_body(c);
            default: ;
        endcase
    endfunction

    function t_reply_view deframe_step(input t_request r);
        t_reply_view v;
        logic        acc;
        acc = 1'b0;
        m_out_v = 1'b0;
        m_out_b = 8'h00;
        case (r.func)
            FN_CONNECT: begin
                m_open  = 1'b1;
                m_reuse = 1'b1;
                m_state = RS_IDLE;
                m_err   = ER_NONE;
            end
            FN_START: begin
                if (m_state != RS_BUSY && m_open) begin
                    acc        = 1'b1;
                    m_state    = RS_BUSY;
                    m_err      = ER_NONE;
                    m_phase    = PH_HEAD;
                    m_head_cnt = 0;
                    m_body_cnt = 0;
                    m_trunc    = 1'b0;
                    m_status   = 16'd0;
                    m_close    = 1'b0;
                end
            end
            FN_BYTE: feed_byte(r.data_byte);
            FN_EOS: begin
                if (m_state == RS_BUSY && m_phase == PH_CLOSE) finish_reply();
                m_open  = 1'b0;
                m_reuse = 1'b0;
                fail_reply(ER_CLOSED);
            end
            FN_DISC: begin
                m_open = 1'b0;
                if (m_state == RS_BUSY) fail_reply(ER_CLOSED);
            end
            default: ;
        endcase
        v.body_valid      = m_out_v;
        v.body_byte       = m_out_b;
        v.request_state   = m_state;
        v.error_code      = m_err;
        v.http_status     = m_status;
        v.reusable        = m_reuse;
        v.truncated       = m_trunc;
        v.start_accepted  = acc;
        v.needs_reconnect = !m_open || !m_reuse || m_state == RS_FAILED;
        return v;
    endfunction

    // stimulus building
    function void push_req(input logic [2:0] f, input logic [7:0] b);
        t_request r;
        r.func = f;
        r.data_byte = b;
        pending_q.push_back(r);
    endfunction

    function void push_text(input string s);
        for (int i = 0; i < s.len(); i++) push_req(FN_BYTE, s[i]);
    endfunction

    function void push_data(input int n);
        for (int i = 0; i < n; i++) push_req(FN_BYTE, 8'($urandom_range(0, 255)));
    endfunction

    function string mix_case(input string s);
        logic [7:0] c;
        for (int i = 0; i < s.len(); i++) begin
            c = s[i];
            if ($urandom_range(0, 1) && c >= "a" && c <= "z") s[i] = c - 8'd32;
            else if ($urandom_range(0, 1) && c >= "A" && c <= "Z") s[i] = c + 8'd32;
        end
        return s;
    endfunction

    function void open_link();
        if (!gen_link_up || $urandom_range(0, 9) == 0) push_req(FN_CONNECT, 8'($urandom));
        gen_link_up = 1'b1;
        push_req(FN_START, 8'($urandom));
    endfunction

    function void push_status_line(input string eol);
        int k;
        k = $urandom_range(0, 19);
        if (k == 0) begin
            push_text("HTTP/2.0 200 OK");
        end else if (k == 1) begin
            push_text("HTTP/1.1 20");
        end else begin
            push_text($urandom_range(0, 1) ? "HTTP/1.1 " : "HTTP/1.0 ");
            if (k == 2) begin
                push_req(FN_BYTE, 8'h00); push_req(FN_BYTE, 8'h00); push_req(FN_BYTE, 8'h00);
            end else if (k == 3) begin
                push_req(FN_BYTE, 8'hFF); push_req(FN_BYTE, 8'hFF); push_req(FN_BYTE, 8'hFF);
            end else if (k == 4) begin
                push_req(FN_BYTE, 8'($urandom_range(32, 126)));
                push_req(FN_BYTE, 8'($urandom_range(32, 126)));
                push_req(FN_BYTE, 8'($urandom_range(32, 126)));
            end else begin
                push_text($sformatf("%0d", $urandom_range(200, 599)));
            end
            push_text(" OK");
        end
        push_text(eol);
    endfunction

    function void push_reply();
        string eol, conn;
        int    frame, n_chunks, sz;
        bit    huge;
        eol   = ($urandom_range(0, 3) == 0) ? "\n" : "\r\n";
        frame = $urandom_range(0, 2);
        huge  = ($urandom_range(0, 14) == 0);
        open_link();
        if ($urandom_range(0, 5) == 0)
            push_text({"HTTP/1.1 1", $sformatf("%0d", $urandom_range(0, 99)), " Continue",
                       eol, eol});
        push_status_line(eol);
        if ($urandom_range(0, 3) == 0) push_text({"X-Note: chunked close", eol});
        case ($urandom_range(0, 3))
            0: conn = "close";
            1: conn = "keep-alive";
            2: conn = "Upgrade, Keep-Alive";
            default: conn = "";
        endcase
        if (conn != "") push_text({mix_case("Connection"), ":\t", mix_case(conn), eol});
        if (frame == 0 || (frame == 1 && $urandom_range(0, 4) == 0)) begin
            sz = $urandom_range(0, 24);
            if (huge) push_text({mix_case("Content-Length"), ": 99999999999", eol});
            else push_text({mix_case("Content-Length"), ": ", $sformatf("%0d", sz), eol});
        end
        if (frame == 1)
            push_text({mix_case("Transfer-Encoding"), ": gzip, ", mix_case("chunked"), eol});
        push_text(eol);
        if ($urandom_range(0, 11) == 0) begin
            push_data($urandom_range(0, 6));
            push_req(FN_DISC, 8'($urandom));
            gen_link_up = 1'b0;
            return;
        end
        if (frame == 0) begin
            push_data(huge ? 5 : sz);
            if (huge) begin
                push_req(FN_EOS, 8'($urandom));
                gen_link_up = 1'b0;
            end
        end else if (frame == 1) begin
            n_chunks = $urandom_range(0, 3);
            for (int i = 0; i < n_chunks; i++) begin
                sz = $urandom_range(1, 20);
                if (huge && i == 0) push_text("fFfFfFfFfF");
                else push_text($sformatf($urandom_range(0, 1) ? "%0x" : "%0X", sz));
                if ($urandom_range(0, 4) == 0)
                    push_text(";ext=aaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaaa");
                push_text(eol);
                push_data(sz);
                if ($urandom_range(0, 5) == 0) push_text("junk");
                push_text(eol);
            end
            if (huge) begin
                push_req(FN_EOS, 8'($urandom));
                gen_link_up = 1'b0;
                return;
            end
            push_text({"0", eol});
            if ($urandom_range(0, 2) == 0) push_text({"X-Trailer: yes", eol});
            push_text(eol);
        end else begin
            push_data($urandom_range(0, 30));
            push_req(FN_EOS, 8'($urandom));
            gen_link_up = 1'b0;
        end
        if ($urandom_range(0, 5) == 0) push_data($urandom_range(1, 4));
        if ($urandom_range(0, 9) == 0) push_req(3'($urandom_range(0, 7)), 8'($urandom));
    endfunction

    // request driver
    always @(negedge i_clk) begin
        logic     nv;
        t_request r;
        if (i_rst_n && !(req_ch.valid && !req_taken)) begin
            nv = 1'b0;
            if (n_req >= 1000 && !pause_done && view_q.size() == 0) pause_done = 1'b1;
            if (n_req >= 1000 && !pause_done) begin
                nv = 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
            end else if (pending_q.size() > 0) begin
                r = pending_q.pop_front();
                nv = 1'b1;
                req_ch.func <= r.func;
                req_ch.data_byte <= r.data_byte;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
                end
            end
            req_ch.valid <= nv;
        end
    end

    // result ready pattern
    always @(negedge i_clk) begin
        logic rdy;
        rdy = 1'b1;
        if (n_req >= 400 && !long_stall_done) begin
            rdy = 1'b0;
            long_stall_cnt++;
            if (long_stall_cnt >= 300) long_stall_done = 1'b1;
        end else begin
            pattern_cnt++;
            if (pattern_cnt >= 64) begin
                pattern_cnt = 0;
                pattern_mode = $urandom_range(0, 3);
            end
            case (pattern_mode)
                1: rdy = $urandom_range(0, 1);
                2: rdy = (pattern_cnt % 4 == 0);
                3: rdy = ($urandom_range(0, 7) != 0);
                default: rdy = 1'b1;
            endcase
        end
        rsp_ch.ready <= rdy;
    end

    // prediction, checking and watchdog
    always @(posedge i_clk) begin
        t_request    r;
        t_reply_view e;
        if (i_rst_n) begin
            req_taken <= req_ch.valid && req_ch.ready;
            if (req_ch.valid && req_ch.ready) begin
                r.func = req_ch.func;
                r.data_byte = req_ch.data_byte;
                view_q.push_back(deframe_step(r));
                n_req++;
            end
            if (rsp_ch.valid && rsp_ch.ready) begin
                n_rsp++;
                if (view_q.size() == 0) begin
                    $error("result with no request pending");
                    n_errors++;
                end else begin
                    e = view_q.pop_front();
                    if (e.body_valid) n_body++;
                    if (e.request_state == RS_DONE) n_done++;
                    if (e.request_state == RS_FAILED) n_failed++;
                    if (rsp_ch.body_valid !== e.body_valid) begin
                        $error("body_valid exp %0d got %0d", e.body_valid, rsp_ch.body_valid);
                        n_errors++;
                    end
                    if (rsp_ch.body_byte !== e.body_byte) begin
                        $error("body_byte exp %0h got %0h", e.body_byte, rsp_ch.body_byte);
                        n_errors++;
                    end
                    if (rsp_ch.request_state !== e.request_state) begin
                        $error("request_state exp %0d got %0d", e.request_state,
                               rsp_ch.request_state);
                        n_errors++;
                    end
                    if (rsp_ch.error_code !== e.error_code) begin
                        $error("error_code exp %0d got %0d", e.error_code, rsp_ch.error_code);
                        n_errors++;
                    end
                    if (rsp_ch.http_status !== e.http_status) begin
                        $error("http_status exp %0d got %0d", $signed(e.http_status),
                               rsp_ch.http_status);
                        n_errors++;
                    end
                    if (rsp_ch.reusable !== e.reusable) begin
                        $error("reusable exp %0d got %0d", e.reusable, rsp_ch.reusable);
                        n_errors++;
                    end
                    if (rsp_ch.truncated !== e.truncated) begin
                        $error("truncated exp %0d got %0d", e.truncated, rsp_ch.truncated);
                        n_errors++;
                    end
                    if (rsp_ch.start_accepted !== e.start_accepted) begin
                        $error("start_accepted exp %0d got %0d", e.start_accepted,
                               rsp_ch.start_accepted);
                        n_errors++;
                    end
                    if (rsp_ch.needs_reconnect !== e.needs_reconnect) begin
                        $error("needs_reconnect exp %0d got %0d", e.needs_reconnect,
                               rsp_ch.needs_reconnect);
                        n_errors++;
                    end
                end
            end
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no traffic for %0d cycles", IDLE_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        int n_replies;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.func = FN_CONNECT;
        req_ch.data_byte = 8'h00;
        rsp_ch.ready = 1'b0;
        req_taken = 1'b0;
        n_req = 0; n_rsp = 0; n_body = 0; n_done = 0; n_failed = 0; n_errors = 0;
        idle_cycles = 0; burst_left = 8; gap_left = 0; pause_done = 0;
        long_stall_cnt = 0; long_stall_done = 0; pattern_cnt = 0; pattern_mode = 0;
        gen_link_up = 1'b0;
        m_state = RS_IDLE; m_err = ER_NONE; m_phase = PH_HEAD;
        m_head_cnt = 0; m_status = 16'd0; m_left = 32'd0;
        m_chunked = 0; m_close = 0; m_reuse = 0; m_open = 0; m_trunc = 0;
        m_line_cnt = 0; m_body_cnt = 0;
        foreach (m_head[i]) m_head[i] = 8'h00;
        foreach (m_line[i]) m_line[i] = 8'h00;

        // directed: unknown codes, idle byte, start while closed, busy start, short head
        push_req(3'd5, 8'hFF);
        push_req(3'd6, 8'h00);
        push_req(3'd7, 8'h5A);
        push_req(FN_BYTE, 8'hA5);
        push_req(FN_START, 8'h00);
        push_req(FN_EOS, 8'h00);
        push_req(FN_DISC, 8'h00);
        push_req(FN_CONNECT, 8'h00);
        push_req(FN_START, 8'h00);
        push_req(FN_START, 8'h00);
        push_text("HTTP/1.1\n\n");
        push_req(FN_EOS, 8'h00);

        n_replies = 0;
        while (pending_q.size() < RANDOM_ITEMS) begin
            if (n_replies == 6) begin
                // head that never ends
                open_link();
                for (int i = 0; i < HEAD_BYTES + 4; i++) push_req(FN_BYTE, "a");
            end else if (n_replies == 20) begin
                // body past the kept limit
                open_link();
                push_text({"HTTP/1.1 200 OK\r\nContent-Length: ",
                           $sformatf("%0d", BODY_BYTES + 5), "\r\n\r\n"});
                push_data(BODY_BYTES + 5);
            end else if ($urandom_range(0, 9) == 0) begin
                push_req(3'($urandom_range(0, 7)), 8'($urandom));
            end else begin
                push_reply();
            end
            n_replies++;
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        wait (pending_q.size() == 0);
        @(posedge i_clk);
        while (req_ch.valid) @(posedge i_clk);
        while (view_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("%0d requests, %0d results checked: %0d body bytes, %0d done, %0d failed",
                 n_req, n_rsp, n_body, n_done, n_failed);
        if (n_errors == 0 && view_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

### http_reply_deframer.f
hw/rtl/hrd_pkg.sv
hw/rtl/hrd_if.sv
hw/rtl/hrd_dp.sv
hw/rtl/hrd_ctrl.sv
hw/rtl/http_reply_deframer.sv
bench/tb_http_reply_deframer.sv
